// ----- design/mwps_pkg.sv -----
package mwps_pkg;

  // Register field width and defaults
  localparam int CFG_W = 13;
  localparam int PIX_W = 32;
  localparam int MAG_W = 31;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [MAG_W-1:0] SMALLEST_NORMAL = 31'h0080_0000;
  localparam logic [MAG_W-1:0] INF_MAG = 31'h7F80_0000;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FIRST_ROW = 3'd2;
  localparam logic [2:0] REG_END_ROW = 3'd3;
  localparam logic [2:0] REG_SIDE_BORDER = 3'd4;
  localparam logic [2:0] REG_EDGE_ROWS = 3'd5;
  localparam logic [2:0] REG_USE_MAGNITUDE = 3'd6;
  localparam logic [2:0] REG_MASK_ENABLE = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic [CFG_W-1:0] first_row;
    logic [CFG_W-1:0] end_row;
    logic [CFG_W-1:0] side_border;
    logic [CFG_W-1:0] edge_rows;
    logic             use_magnitude;
    logic             mask_enable;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [CFG_W-1:0] peak_col;
    logic [CFG_W-1:0] peak_row;
    logic [PIX_W-1:0] peak_bits;
  } result_t;

endpackage

// ----- design/mwps_cfg.sv -----
module mwps_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [4:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready,
  output mwps_pkg::cfg_t cfg
);
  import mwps_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx = cfg_paddr[4:2];
  assign cfg = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:   cfg_nxt.image_width = cfg_pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_nxt.image_height = cfg_pwdata[CFG_W-1:0];
        REG_FIRST_ROW:     cfg_nxt.first_row = cfg_pwdata[CFG_W-1:0];
        REG_END_ROW:       cfg_nxt.end_row = cfg_pwdata[CFG_W-1:0];
        REG_SIDE_BORDER:   cfg_nxt.side_border = cfg_pwdata[CFG_W-1:0];
        REG_EDGE_ROWS:     cfg_nxt.edge_rows = cfg_pwdata[CFG_W-1:0];
        REG_USE_MAGNITUDE: cfg_nxt.use_magnitude = cfg_pwdata[0];
        REG_MASK_ENABLE:   cfg_nxt.mask_enable = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= CFG_W'(4096);
      cfg_r.image_height  <= CFG_W'(4096);
      cfg_r.first_row     <= '0;
      cfg_r.end_row       <= CFG_W'(4096);
      cfg_r.side_border   <= '0;
      cfg_r.edge_rows     <= '0;
      cfg_r.use_magnitude <= 1'b0;
      cfg_r.mask_enable   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    case (idx)
      REG_IMAGE_WIDTH:   cfg_prdata = 32'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:  cfg_prdata = 32'(cfg_r.image_height);
      REG_FIRST_ROW:     cfg_prdata = 32'(cfg_r.first_row);
      REG_END_ROW:       cfg_prdata = 32'(cfg_r.end_row);
      REG_SIDE_BORDER:   cfg_prdata = 32'(cfg_r.side_border);
      REG_EDGE_ROWS:     cfg_prdata = 32'(cfg_r.edge_rows);
      REG_USE_MAGNITUDE: cfg_prdata = 32'(cfg_r.use_magnitude);
      REG_MASK_ENABLE:   cfg_prdata = 32'(cfg_r.mask_enable);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

// ----- design/mwps_core.sv -----
module mwps_core #(
  parameter int MAX_WIDTH = mwps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mwps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mwps_pkg::cfg_t              cfg,
  input  logic                        step,
  input  logic [mwps_pkg::PIX_W-1:0]  pix,
  input  logic                        mbit,
  output logic                        frame_end,
  output mwps_pkg::result_t           res
);
  import mwps_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int XW0 = (WDW > HDW) ? WDW : HDW;
  localparam int XW  = ((XW0 > CFG_W) ? XW0 : CFG_W) + 1;

  logic [CW-1:0]    col_r, col_nxt, best_col_r, best_col_nxt;
  logic [RW-1:0]    row_r, row_nxt, best_row_r, best_row_nxt;
  logic [MAG_W-1:0] best_mag_r, best_mag_nxt;
  logic [PIX_W-1:0] best_bits_r, best_bits_nxt;
  logic             have_r, have_nxt;

  logic [XW-1:0] w_x, h_x, col_x, row_x, side_x, edge_x, ylo_x, yhi_x, hme_x;
  logic [XW-1:0] first_x, end_x;
  logic [MAG_W-1:0] mag;
  logic          in_win, ok, take, row_wrap;

  // Clamp image size and widen operands
  always_comb begin
    if (cfg.image_width == '0) w_x = XW'(1);
    else if (XW'(cfg.image_width) > XW'(MAX_WIDTH)) w_x = XW'(MAX_WIDTH);
    else w_x = XW'(cfg.image_width);
    if (cfg.image_height == '0) h_x = XW'(1);
    else if (XW'(cfg.image_height) > XW'(MAX_HEIGHT)) h_x = XW'(MAX_HEIGHT);
    else h_x = XW'(cfg.image_height);
  end

  assign col_x   = XW'(col_r);
  assign row_x   = XW'(row_r);
  assign side_x  = XW'(cfg.side_border);
  assign edge_x  = XW'(cfg.edge_rows);
  assign first_x = XW'(cfg.first_row);
  assign end_x   = XW'(cfg.end_row);
  assign hme_x   = h_x - edge_x;
  assign ylo_x   = (first_x > edge_x) ? first_x : edge_x;
  assign yhi_x   = (end_x < hme_x) ? end_x : hme_x;

  // Window test
  assign in_win = (side_x <= w_x) && (col_x >= side_x) && (col_x < w_x - side_x) &&
                  (edge_x <= h_x) && (row_x >= ylo_x) && (row_x < yhi_x);

  // Qualify the pixel
  assign mag = pix[MAG_W-1:0];
  assign ok = in_win && !(pix[PIX_W-1] && !cfg.use_magnitude) && (mag <= INF_MAG) &&
              !(cfg.mask_enable && !mbit);
  assign take = ok && (mag > best_mag_r);

  assign row_wrap  = (col_x + XW'(1)) >= w_x;
  assign frame_end = row_wrap && ((row_x + XW'(1)) >= h_x);

  // Peak update after this pixel
  always_comb begin
    best_mag_nxt  = best_mag_r;
    best_bits_nxt = best_bits_r;
    best_col_nxt  = best_col_r;
    best_row_nxt  = best_row_r;
    have_nxt      = have_r;
    if (take) begin
      best_mag_nxt  = mag;
      best_bits_nxt = pix;
      best_col_nxt  = col_r;
      best_row_nxt  = row_r;
      have_nxt      = 1'b1;
    end
  end

  // Result of the frame, valid when frame_end
  always_comb begin
    res.found     = have_nxt;
    res.peak_col  = have_nxt ? CFG_W'(best_col_nxt) : w_x[CFG_W-1:0];
    res.peak_row  = have_nxt ? CFG_W'(best_row_nxt) : h_x[CFG_W-1:0];
    res.peak_bits = have_nxt ? best_bits_nxt : '0;
  end

  // Position counters
  always_comb begin
    col_nxt = row_wrap ? '0 : CW'(col_x + XW'(1));
    row_nxt = row_r;
    if (row_wrap) row_nxt = frame_end ? '0 : RW'(row_x + XW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      best_mag_r  <= SMALLEST_NORMAL;
      best_bits_r <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
      have_r      <= 1'b0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (frame_end) begin
        best_mag_r  <= SMALLEST_NORMAL;
        best_bits_r <= '0;
        best_col_r  <= '0;
        best_row_r  <= '0;
        have_r      <= 1'b0;
      end else begin
        best_mag_r  <= best_mag_nxt;
        best_bits_r <= best_bits_nxt;
        best_col_r  <= best_col_nxt;
        best_row_r  <= best_row_nxt;
        have_r      <= have_nxt;
      end
    end
  end

endmodule

// ----- design/masked_windowed_peak_search_unit.sv -----
// Masked windowed peak search over a raster-order stream of float pixels.
// Input channel: one pixel per transaction, in_tdata = pixel_bits, in_tuser =
// mask_bit. After the last pixel of a frame one result transaction leaves on
// the output channel: out_tuser = found, out_tdata = peak_col, peak_row and
// peak_bits (image width/height and zero when no pixel qualified).
// The user writes configuration over the APB-style port only while the stream is
// idle (the block does not enforce this): frame geometry, window borders, row range,
// magnitude mode and masking. Throughput: one pixel per cycle, except that a frame's
// last pixel waits while a pending result is stalled. A pixel is captured in an input
// register, then compared and folded into the tracker when it advances; the frame
// result lands in the output register on that same edge, and is offered from there.
// If the receiver stalls with a result pending, pixels keep flowing until a
// second frame end reaches the tracker; that pixel then waits in the input
// register and in_tready drops until the pending result is taken.
// Reset (synchronous, active low) restores register defaults, clears the
// position counters and the peak tracker and empties both registers.
module masked_windowed_peak_search_unit #(
  parameter int MAX_WIDTH = mwps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mwps_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_bits
  input  logic        in_tuser,   // [0] mask_bit
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [12:0] peak_col, [25:13] peak_row, [57:26] peak_bits
  output logic        out_tuser,  // [0] found
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mwps_pkg::*;

  cfg_t             cfg;
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_mbit_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, res;
  logic             frame_end, out_free, s1_adv, in_acc;

  mwps_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  mwps_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (s1_adv),
    .pix      (s1_pix_r),
    .mbit     (s1_mbit_r),
    .frame_end(frame_end),
    .res      (res)
  );

  // Handshake control
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!frame_end || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_adv && frame_end) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_tdata;
      s1_mbit_r <= in_tuser;
    end
    if (s1_adv && frame_end) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.found;
  assign out_tdata  = {6'b0, out_r.peak_bits, out_r.peak_row, out_r.peak_col};

endmodule

// ----- sim/masked_windowed_peak_search_unit_test.sv -----
`timescale 1ns / 100ps

module masked_windowed_peak_search_unit_test;
  import mwps_pkg::*;

  // Peak tracker prediction and ordered store of frame results
  class peak_scoreboard;
    logic [CFG_W-1:0] width_reg, height_reg, first_row, end_row, side_border, edge_rows;
    bit use_magnitude, mask_enable;
    int unsigned col_count, row_count, best_col, best_row;
    logic [MAG_W-1:0] best_mag;
    logic [PIX_W-1:0] best_bits;
    bit have_peak;
    result_t frame_results[$];
    int errors;

    function new();
      width_reg = 4096; height_reg = 4096; first_row = 0; end_row = 4096;
      side_border = 0; edge_rows = 0; use_magnitude = 0; mask_enable = 0;
      errors = 0;
      clear_tracker();
    endfunction

    function void clear_tracker();
      col_count = 0; row_count = 0; best_col = 0; best_row = 0;
      best_mag = SMALLEST_NORMAL; best_bits = 0; have_peak = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_IMAGE_WIDTH: width_reg = val[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = val[CFG_W-1:0];
        REG_FIRST_ROW: first_row = val[CFG_W-1:0];
        REG_END_ROW: end_row = val[CFG_W-1:0];
        REG_SIDE_BORDER: side_border = val[CFG_W-1:0];
        REG_EDGE_ROWS: edge_rows = val[CFG_W-1:0];
        REG_USE_MAGNITUDE: use_magnitude = val[0];
        REG_MASK_ENABLE: mask_enable = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function bit inside_window(int unsigned c, int unsigned r, int unsigned w, int unsigned h);
      int unsigned ystart, yend;
      if (side_border > w) return 0;
      if (c < side_border || c >= w - side_border) return 0;
      if (edge_rows > h) return 0;
      ystart = (first_row > edge_rows) ? first_row : edge_rows;
      yend = h - edge_rows;
      if (end_row < yend) yend = end_row;
      return (r >= ystart) && (r < yend);
    endfunction

    // Fold one accepted pixel into the tracker
    function void note_pixel(logic [31:0] bits, bit mbit);
      int unsigned w, h;
      logic [MAG_W-1:0] mag;
      bit ok;
      result_t res;
      w = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      mag = bits[30:0];
      ok = inside_window(col_count, row_count, w, h);
      if (bits[31] && !use_magnitude) ok = 0;
      if (mag > INF_MAG) ok = 0;
      if (mask_enable && !mbit) ok = 0;
      if (ok && mag > best_mag) begin
        best_mag = mag; best_bits = bits;
        best_col = col_count; best_row = row_count; have_peak = 1;
      end
      if (col_count + 1 >= w) begin
        col_count = 0;
        if (row_count + 1 >= h) begin
          res.found = have_peak;
          res.peak_col = have_peak ? best_col[CFG_W-1:0] : w[CFG_W-1:0];
          res.peak_row = have_peak ? best_row[CFG_W-1:0] : h[CFG_W-1:0];
          res.peak_bits = have_peak ? best_bits : '0;
          frame_results.push_back(res);
          clear_tracker();
        end else row_count++;
      end else col_count++;
    endfunction

    // Compare one result transaction with the oldest pending frame result
    function void check_result(logic found, logic [63:0] data);
      result_t exp_res;
      if (frame_results.size() == 0) begin
        $error("unexpected result: found=%0d data=%h", found, data);
        errors++;
        return;
      end
      exp_res = frame_results.pop_front();
      if (found !== exp_res.found) begin
        $error("found: expected %0d, got %0d", exp_res.found, found); errors++;
      end
      if (data[12:0] !== exp_res.peak_col) begin
        $error("peak_col: expected %0d, got %0d", exp_res.peak_col, data[12:0]); errors++;
      end
      if (data[25:13] !== exp_res.peak_row) begin
        $error("peak_row: expected %0d, got %0d", exp_res.peak_row, data[25:13]); errors++;
      end
      if (data[57:26] !== exp_res.peak_bits) begin
        $error("peak_bits: expected %h, got %h", exp_res.peak_bits, data[57:26]); errors++;
      end
      if (data[63:58] !== 6'd0) begin
        $error("pad: expected 0, got %h", data[63:58]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0;
  logic [31:0] in_tdata = 0;
  logic in_tready, out_tvalid, out_tuser, cfg_pready;
  logic out_tready = 0;
  logic [63:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;

  int send_idle_pct = 0, recv_stall_pct = 0;
  peak_scoreboard sb = new();

  masked_windowed_peak_search_unit dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Receiver: random stall, check at rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Register write; the pixel stream is idled first
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    in_tvalid <= 0;
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Drive one pixel transaction, random idle beforehand
  task automatic send_pixel(logic [31:0] bits, bit mbit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1; in_tdata <= bits; in_tuser <= mbit;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(bits, mbit);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.frame_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(9))
      0: return 32'h7F80_0000 | ($urandom_range(1) << 31);
      1: return {$urandom_range(1) == 1, 31'(31'h7F80_0000 + $urandom_range(1, 100))};
      2: return {$urandom_range(1) == 1, 31'(31'h0080_0000 + $urandom_range(1) - 1)};
      3: return {$urandom_range(1) == 1, 31'($urandom_range(32'h007F_FFFF))};
      4: return 32'h3F80_0000 | ($urandom_range(1) << 31);
      default: return $urandom();
    endcase
  endfunction

  // Set a frame geometry and random window, mode and mask registers, then send some whole frames of random pixels
  task automatic run_frames(int w, int h, int frames);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_FIRST_ROW, $urandom_range(h));
    write_reg(REG_END_ROW, $urandom_range(h + 1));
    write_reg(REG_SIDE_BORDER, ($urandom_range(4) == 0) ? $urandom_range(w + 2) : $urandom_range(w / 3));
    write_reg(REG_EDGE_ROWS, ($urandom_range(4) == 0) ? $urandom_range(h + 2) : $urandom_range(h / 3));
    write_reg(REG_USE_MAGNITUDE, $urandom_range(1));
    write_reg(REG_MASK_ENABLE, $urandom_range(1));
    repeat (frames * (w == 0 ? 1 : w) * (h == 0 ? 1 : h)) send_pixel(rand_pixel(), $urandom_range(1));
    drain();
  endtask

  initial begin
    #200000000;
    $display("masked_windowed_peak_search_unit_test: done, errors");
    $finish;
  end

  initial begin
    int phase;
    repeat (11) @(negedge clk);
    rst_n <= 1;

    // Directed: 1x1 frames over edge values, then a tie and a window check
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_pixel(32'h3F80_0000, 0);
    send_pixel(32'h0080_0000, 1);
    send_pixel(32'h7F80_0000, 1);
    send_pixel(32'hFF80_0000, 1);
    send_pixel(32'h7FC0_0000, 1);
    send_pixel(32'h8000_0000, 1);
    send_pixel(32'h0000_0001, 1);
    send_pixel(32'hFFFF_FFFF, 1);
    write_reg(REG_USE_MAGNITUDE, 1);
    send_pixel(32'hC000_0000, 0);
    send_pixel(32'hFF80_0000, 1);
    write_reg(REG_MASK_ENABLE, 1);
    send_pixel(32'h4000_0000, 0);
    send_pixel(32'h4000_0000, 1);
    drain();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_MASK_ENABLE, 0);
    send_pixel(32'h4000_0000, 1); send_pixel(32'hC000_0000, 1); send_pixel(32'h4000_0000, 1);
    send_pixel(32'h4040_0000, 1); send_pixel(32'h4040_0000, 1); send_pixel(32'h3F00_0000, 1);
    write_reg(REG_SIDE_BORDER, 2);
    repeat (6) send_pixel(32'h4000_0000, 1);
    drain();
    write_reg(REG_SIDE_BORDER, 0);
    write_reg(REG_FIRST_ROW, 1);
    write_reg(REG_END_ROW, 0);
    write_reg(REG_EDGE_ROWS, 4096);
    repeat (6) send_pixel(32'h4000_0000, 1);
    drain();
    write_reg(REG_EDGE_ROWS, 0);
    write_reg(REG_END_ROW, 4096);

    // Random: idle/stall phases over many small frame geometries
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      repeat (21) run_frames($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(1, 3));
    end
    send_idle_pct = 0; recv_stall_pct = 0;

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.frame_results.size() == 0)
      $display("masked_windowed_peak_search_unit_test: done, clean");
    else
      $display("masked_windowed_peak_search_unit_test: done, errors");
    $finish;
  end

endmodule
